FILE: design/spq_pkg.sv
// Shared types, codes and defaults for the strict priority queue scheduler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package spq_pkg;

	localparam int unsigned NUM_CLASSES_DEF = 16;
	localparam int unsigned CLASS_DEPTH_DEF = 8;

	localparam int unsigned SIZE_W  = 16;
	localparam int unsigned CLASS_W = 4;
	localparam int unsigned FLOW_W  = 8;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned DROP_W  = 16;

	localparam logic [DROP_W-1:0] DROP_MAX = {DROP_W{1'b1}};

	// commands
	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] ST_ENQUEUED = 2'd0;
	localparam logic [STAT_W-1:0] ST_DROPPED  = 2'd1;
	localparam logic [STAT_W-1:0] ST_DEQUEUED = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd3;

	typedef struct packed {
		logic              cmd;
		logic [SIZE_W-1:0]  pkt_size;
		logic [CLASS_W-1:0] pkt_class;
		logic [FLOW_W-1:0]  pkt_flow;
	} in_item_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [SIZE_W-1:0]  out_size;
		logic [CLASS_W-1:0] out_class;
		logic [FLOW_W-1:0]  out_flow;
		logic [DROP_W-1:0]  drops_total;
	} out_item_t;

	// stored packet descriptor
	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic [FLOW_W-1:0] flow;
	} desc_t;

	// per-transaction outcome from the queue controller
	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [CLASS_W-1:0] out_class;
		logic [DROP_W-1:0]  drops_total;
	} decision_t;

endpackage

FILE: design/spq_mem.sv
// Descriptor RAM: one ring per class, single port, registered read data.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_mem
	import spq_pkg::*;
#(
	parameter int unsigned DEPTH  = NUM_CLASSES_DEF * CLASS_DEPTH_DEF,
	parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  desc_t             wdata,
	output desc_t             rdata
);

	desc_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

FILE: design/spq_ctrl.sv
// Queue controller: per-class head/tail/count, highest non-empty class pick,
// saturating drop counter and RAM address generation. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_ctrl
	import spq_pkg::*;
#(
	parameter int unsigned NUM_CLASSES = NUM_CLASSES_DEF,
	parameter int unsigned CLASS_DEPTH = CLASS_DEPTH_DEF,
	parameter int unsigned ADDR_W      = $clog2(NUM_CLASSES * CLASS_DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  in_item_t          item,
	output decision_t         dec,
	output logic              mem_we,
	output logic              mem_re,
	output logic [ADDR_W-1:0] mem_addr
);

	localparam int unsigned CLS_W = $clog2(NUM_CLASSES);
	localparam int unsigned PTR_W = $clog2(CLASS_DEPTH);
	localparam int unsigned CNT_W = $clog2(CLASS_DEPTH + 1);

	logic [PTR_W-1:0] head_q  [NUM_CLASSES];
	logic [PTR_W-1:0] tail_q  [NUM_CLASSES];
	logic [CNT_W-1:0] count_q [NUM_CLASSES];
	logic [DROP_W-1:0] drop_q;

	logic [NUM_CLASSES-1:0] nonempty;
	logic [CLS_W-1:0]       enq_cls;
	logic [CLS_W-1:0]       deq_cls;
	logic                   any_pkt;
	logic                   enq_full;
	logic                   do_enq;
	logic                   do_deq;
	logic                   do_drop;
	logic [DROP_W-1:0]      drop_upd;

	// out-of-range class folds onto the top class
	always_comb begin
		if (32'(item.pkt_class) >= NUM_CLASSES) begin
			enq_cls = CLS_W'(NUM_CLASSES - 1);
		end else begin
			enq_cls = CLS_W'(item.pkt_class);
		end
	end

	// priority encoder, highest-numbered non-empty class wins
	always_comb begin
		deq_cls = '0;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			nonempty[c] = (count_q[c] != '0);
			if (nonempty[c]) begin
				deq_cls = CLS_W'(c);
			end
		end
		any_pkt = |nonempty;
	end

	assign enq_full = (count_q[enq_cls] == CNT_W'(CLASS_DEPTH));

	always_comb begin
		do_enq    = 1'b0;
		do_deq    = 1'b0;
		do_drop   = 1'b0;
		dec       = '0;
		mem_addr  = '0;
		if (item.cmd == CMD_ENQ) begin
			mem_addr = ADDR_W'(enq_cls) * ADDR_W'(CLASS_DEPTH) + ADDR_W'(tail_q[enq_cls]);
			if (enq_full) begin
				do_drop    = 1'b1;
				dec.status = ST_DROPPED;
			end else begin
				do_enq     = 1'b1;
				dec.status = ST_ENQUEUED;
			end
		end else begin
			mem_addr = ADDR_W'(deq_cls) * ADDR_W'(CLASS_DEPTH) + ADDR_W'(head_q[deq_cls]);
			if (any_pkt) begin
				do_deq        = 1'b1;
				dec.status    = ST_DEQUEUED;
				dec.out_class = CLASS_W'(deq_cls);
			end else begin
				dec.status = ST_EMPTY;
			end
		end
		drop_upd = (do_drop && drop_q != DROP_MAX) ? drop_q + 1'b1 : drop_q;
		dec.drops_total = drop_upd;
	end

	assign mem_we = fire && do_enq;
	assign mem_re = fire && do_deq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				head_q[c]  <= '0;
				tail_q[c]  <= '0;
				count_q[c] <= '0;
			end
			drop_q <= '0;
		end else if (fire) begin
			drop_q <= drop_upd;
			if (do_enq) begin
				tail_q[enq_cls]  <= (tail_q[enq_cls] == PTR_W'(CLASS_DEPTH - 1)) ?
					'0 : tail_q[enq_cls] + 1'b1;
				count_q[enq_cls] <= count_q[enq_cls] + 1'b1;
			end
			if (do_deq) begin
				head_q[deq_cls]  <= (head_q[deq_cls] == PTR_W'(CLASS_DEPTH - 1)) ?
					'0 : head_q[deq_cls] + 1'b1;
				count_q[deq_cls] <= count_q[deq_cls] - 1'b1;
			end
		end
	end

endmodule

FILE: design/strict_priority_queue_scheduler.sv
// Top level of the strict priority queue scheduler: input stage, result stage.
// Depends on spq_pkg, spq_ctrl and spq_mem.
//
//   channel | valid     | ready     | payload
//   --------+-----------+-----------+---------------------
//   input   | in_valid  | in_ready  | in_data  (in_item_t)
//   result  | out_valid | out_ready | out_data (out_item_t)
//
// One transaction per cycle sustained while the result side is not stalled; a
// transaction passes the input register, then the RAM read / result register,
// before out_valid rises.
// The single-port descriptor RAM with registered read is why the result stage is registered.
// Reset empties every class and clears the drop counter; RAM contents are
// not cleared. A stalled result holds both stages; the input stage still
// takes one transaction while the result stage waits.
`timescale 1ns / 1ps

module strict_priority_queue_scheduler
	import spq_pkg::*;
#(
	parameter int unsigned NUM_CLASSES = NUM_CLASSES_DEF,
	parameter int unsigned CLASS_DEPTH = CLASS_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int unsigned DEPTH  = NUM_CLASSES * CLASS_DEPTH;
	localparam int unsigned ADDR_W = $clog2(DEPTH);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	decision_t dec_s2;

	logic              adv;
	logic              fire;
	decision_t         dec;
	logic              mem_we;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_addr;
	desc_t             wdata;
	desc_t             rdata;

	assign adv      = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv;
	assign fire     = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (fire) begin
			dec_s2 <= dec;
		end
	end

	spq_ctrl #(
		.NUM_CLASSES (NUM_CLASSES),
		.CLASS_DEPTH (CLASS_DEPTH),
		.ADDR_W      (ADDR_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (item_s1),
		.dec      (dec),
		.mem_we   (mem_we),
		.mem_re   (mem_re),
		.mem_addr (mem_addr)
	);

	assign wdata.size = item_s1.pkt_size;
	assign wdata.flow = item_s1.pkt_flow;

	spq_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (wdata),
		.rdata (rdata)
	);

	// RAM read data only updates on a dequeue, so it holds through stalls
	always_comb begin
		out_data             = '0;
		out_data.status      = dec_s2.status;
		out_data.out_class   = dec_s2.out_class;
		out_data.drops_total = dec_s2.drops_total;
		if (dec_s2.status == ST_DEQUEUED) begin
			out_data.out_size = rdata.size;
			out_data.out_flow = rdata.flow;
		end
	end

	assign out_valid = valid_s2;

endmodule

FILE: sim/spq_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the strict priority queue scheduler: keeps its own class rings,
// predicts one result per accepted transaction and compares results in order.
// Depends on spq_pkg.

module spq_checker
	import spq_pkg::*;
#(
	parameter int unsigned NUM_CLASSES = NUM_CLASSES_DEF,
	parameter int unsigned CLASS_DEPTH = CLASS_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_data,
	output int        fail_count,
	output int        pending,
	output int        num_enq,
	output int        num_drop,
	output int        num_deq,
	output int        num_empty,
	output int        last_drops
);

	localparam int unsigned PTR_W  = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
	localparam int unsigned FILL_W = $clog2(CLASS_DEPTH + 1);

	desc_t             slot_mem  [NUM_CLASSES][CLASS_DEPTH];
	logic [PTR_W-1:0]  rd_ptr    [NUM_CLASSES];
	logic [PTR_W-1:0]  wr_ptr    [NUM_CLASSES];
	logic [FILL_W-1:0] occupancy [NUM_CLASSES];
	logic [DROP_W-1:0] drop_cnt;
	out_item_t         sched_results_q [$];

	int errs;
	int n_fail, n_enq, n_drop, n_deq, n_empty;
	out_item_t want;

	initial begin
		for (int c = 0; c < NUM_CLASSES; c++) begin
			rd_ptr[c]    = '0;
			wr_ptr[c]    = '0;
			occupancy[c] = '0;
		end
		drop_cnt = '0;
		n_fail = 0;
		n_enq = 0;
		n_drop = 0;
		n_deq = 0;
		n_empty = 0;
		fail_count = 0;
		pending = 0;
		num_enq = 0;
		num_drop = 0;
		num_deq = 0;
		num_empty = 0;
		last_drops = 0;
	end

	function automatic logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] p);
		return (p == PTR_W'(CLASS_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// updates the ring state and returns the result the block must produce
	function automatic out_item_t schedule_op(in_item_t it);
		out_item_t   res;
		int unsigned cls;
		desc_t       d;
		res = '0;
		if (it.cmd == CMD_ENQ) begin
			cls = it.pkt_class;
			if (cls >= NUM_CLASSES)
				cls = NUM_CLASSES - 1;
			if (occupancy[cls] >= FILL_W'(CLASS_DEPTH)) begin
				if (drop_cnt != DROP_MAX)
					drop_cnt = drop_cnt + 1'b1;
				res.status = ST_DROPPED;
			end else begin
				slot_mem[cls][wr_ptr[cls]] = '{size: it.pkt_size, flow: it.pkt_flow};
				wr_ptr[cls] = ring_next(wr_ptr[cls]);
				occupancy[cls] = occupancy[cls] + 1'b1;
				res.status = ST_ENQUEUED;
			end
		end else begin
			res.status = ST_EMPTY;
			// highest-numbered non-empty class wins
			for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
				if (res.status == ST_EMPTY && occupancy[c] != 0) begin
					d = slot_mem[c][rd_ptr[c]];
					rd_ptr[c] = ring_next(rd_ptr[c]);
					occupancy[c] = occupancy[c] - 1'b1;
					res.status    = ST_DEQUEUED;
					res.out_size  = d.size;
					res.out_class = CLASS_W'(c);
					res.out_flow  = d.flow;
				end
			end
		end
		res.drops_total = drop_cnt;
		return res;
	endfunction

	function automatic int field_diff(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sched_results_q.push_back(schedule_op(in_data));
			if (out_valid && out_ready) begin
				if (sched_results_q.size() == 0) begin
					$display("%0t ns: result with nothing expected, got %h", $time, out_data);
					n_fail++;
				end else begin
					want = sched_results_q.pop_front();
					errs = field_diff("status", want.status, out_data.status)
						+ field_diff("out_size", want.out_size, out_data.out_size)
						+ field_diff("out_class", want.out_class, out_data.out_class)
						+ field_diff("out_flow", want.out_flow, out_data.out_flow)
						+ field_diff("drops_total", want.drops_total, out_data.drops_total);
					if (errs != 0)
						n_fail++;
					case (want.status)
						ST_ENQUEUED: n_enq++;
						ST_DROPPED:  n_drop++;
						ST_DEQUEUED: n_deq++;
						default:     n_empty++;
					endcase
				end
			end
			fail_count <= n_fail;
			pending    <= sched_results_q.size();
			num_enq    <= n_enq;
			num_drop   <= n_drop;
			num_deq    <= n_deq;
			num_empty  <= n_empty;
			last_drops <= drop_cnt;
		end
	end

endmodule

FILE: sim/tb_strict_priority_queue_scheduler.sv
`timescale 1ns / 1ps
// Testbench top for the strict priority queue scheduler: clock, reset, stimulus
// and verdict. Depends on spq_pkg, spq_checker and the scheduler RTL.

module tb_strict_priority_queue_scheduler;
	import spq_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	int fail_count, pending, num_enq, num_drop, num_deq, num_empty, last_drops;
	int n_sent = 0;
	int rx_hold = 0;
	bit tx_throttle = 1'b0;
	bit rx_throttle = 1'b0;

	always #5 clk = ~clk;

	strict_priority_queue_scheduler u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	spq_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.fail_count (fail_count),
		.pending    (pending),
		.num_enq    (num_enq),
		.num_drop   (num_drop),
		.num_deq    (num_deq),
		.num_empty  (num_empty),
		.last_drops (last_drops)
	);

	// mostly short idle stretches, now and then a long one
	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
	endfunction

	function automatic in_item_t pkt(logic cmd, logic [SIZE_W-1:0] size,
		logic [CLASS_W-1:0] cls, logic [FLOW_W-1:0] flow);
		return '{cmd: cmd, pkt_size: size, pkt_class: cls, pkt_flow: flow};
	endfunction

	function automatic in_item_t rand_item(int enq_pct, int cls_lo, int cls_hi);
		in_item_t it;
		it.cmd = ($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ;
		case ($urandom_range(0, 7))
			0:       it.pkt_size = '0;
			1:       it.pkt_size = '1;
			default: it.pkt_size = SIZE_W'($urandom);
		endcase
		it.pkt_class = CLASS_W'($urandom_range(cls_lo, cls_hi));
		it.pkt_flow  = FLOW_W'($urandom);
		return it;
	endfunction

	// result side back-pressure
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			out_ready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else begin
			out_ready <= 1'b1;
			if (rx_throttle && $urandom_range(0, 4) == 0)
				rx_hold <= gap_len();
		end
	end

	// valid stays high across back-to-back transactions
	task automatic send(in_item_t it);
		int gap;
		gap = (tx_throttle && $urandom_range(0, 2) == 0) ? gap_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		n_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	initial begin
		#20_000_000;
		$display("Timeout with %0d results outstanding", pending);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int enq_pct, cls_lo, cls_hi;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty, field extremes, priority order, full class and drop
		send(pkt(CMD_DEQ, '1, '1, '1));
		send(pkt(CMD_ENQ, '0, 4'd0, '0));
		send(pkt(CMD_ENQ, '1, 4'd15, '1));
		send(pkt(CMD_ENQ, 16'h5a5a, 4'd7, 8'ha5));
		send(pkt(CMD_DEQ, '0, '0, '0));
		send(pkt(CMD_DEQ, 16'h1234, 4'd3, 8'h56));
		send(pkt(CMD_DEQ, '0, '0, '0));
		send(pkt(CMD_DEQ, '0, '0, '0));
		for (int i = 0; i < 9; i++)
			send(pkt(CMD_ENQ, SIZE_W'(i * 16'h1111 + 1), 4'd15, FLOW_W'(8'hf0 + i)));
		send(pkt(CMD_ENQ, 16'hbeef, 4'd3, 8'h3c));
		send(pkt(CMD_DEQ, '0, '0, '0));
		send(pkt(CMD_DEQ, '0, '0, '0));
		// refill wraps the tail, third one drops again
		for (int i = 0; i < 3; i++)
			send(pkt(CMD_ENQ, SIZE_W'(16'hfff0 + i), 4'd15, FLOW_W'(i)));
		drain();

		// random: each phase picks its enqueue share at random, from mostly draining to mostly filling
		for (int seg = 0; seg < 35; seg++) begin
			tx_throttle = ($urandom_range(0, 3) != 0);
			rx_throttle = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 3))
				0:       enq_pct = 15;
				1:       enq_pct = 50;
				2:       enq_pct = 70;
				default: enq_pct = 90;
			endcase
			if ($urandom_range(0, 1) == 0) begin
				cls_lo = 0;
				cls_hi = 15;
			end else begin
				cls_lo = $urandom_range(0, 14);
				cls_hi = cls_lo + 1;
			end
			for (int i = 0; i < 50; i++)
				send(rand_item(enq_pct, cls_lo, cls_hi));
			if (seg == 17)
				drain();
		end
		drain();

		// empty every class, then a short mixed tail
		tx_throttle = 1'b1;
		rx_throttle = 1'b1;
		for (int i = 0; i < 140; i++)
			send(rand_item(0, 0, 15));
		for (int i = 0; i < 40; i++)
			send(rand_item(60, 0, 15));
		in_valid <= 1'b0;
		drain();
		repeat (6) @(posedge clk);

		$display("Covered %0d transactions: %0d enqueued, %0d dropped, %0d dequeued, %0d empty",
			n_sent, num_enq, num_drop, num_deq, num_empty);
		$display("Drop counter ended at %0d, saturation limit %0d", last_drops, DROP_MAX);
		if (pending != 0)
			$display("%0d expected results never arrived", pending);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: files.f
design/spq_pkg.sv
design/spq_mem.sv
design/spq_ctrl.sv
design/strict_priority_queue_scheduler.sv
sim/spq_checker.sv
sim/tb_strict_priority_queue_scheduler.sv
